/* hw/rtl/pwlc_pkg.sv */
package pwlc_pkg;

  // Number of table entries and the address width that follows from it.
  localparam int unsigned SEGMENTS = 16;
  localparam int unsigned SEG_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

  // Slope divider: 32-bit magnitude shifted up by 16 fraction bits.
  localparam int unsigned DQ_W      = 48;
  localparam int unsigned DIV_CNT_W = $clog2(DQ_W);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CONV = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         segment_index;
    logic signed [31:0] seg_min_pixel;
    logic signed [31:0] seg_max_pixel;
    logic signed [31:0] seg_min_value;
    logic signed [31:0] seg_max_value;
    logic signed [31:0] sample_value;
    logic               sample_missing;
  } pwlc_in_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       out_of_range;
    logic       degenerate_segment;
    logic [3:0] segment_used;
  } pwlc_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic div_step;
    logic wr_en;
    logic srch_adv;
    logic diff_en;
    logic mlo_en;
    logic mhi_en;
    logic acc_en;
    logic scl_en;
    logic sum_en;
    logic out_load;
  } pwlc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic req_conv;
    logic req_ident;
    logic req_degen;
    logic div_last;
    logic srch_stop;
  } pwlc_sts_t;

endpackage

/* hw/rtl/pwlc_ctrl.sv */
module pwlc_ctrl import pwlc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pwlc_sts_t sts_i,
  output pwlc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_SEARCH,
    ST_DIFF,
    ST_MLO,
    ST_MHI,
    ST_ACC,
    ST_SCALE,
    ST_SUM,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (fire) begin
          cmd_o.capture = 1'b1;
          if (sts_i.req_conv) begin
            state_d = sts_i.req_ident ? ST_FIN : ST_SEARCH;
          end else begin
            state_d = sts_i.req_degen ? ST_WRITE : ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_en = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_SEARCH: begin
        if (sts_i.srch_stop) begin
          state_d = ST_DIFF;
        end else begin
          cmd_o.srch_adv = 1'b1;
        end
      end
      ST_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = ST_MLO;
      end
      ST_MLO: begin
        cmd_o.mlo_en = 1'b1;
        state_d      = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.mhi_en = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scl_en = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/pwlc_dp.sv */
module pwlc_dp import pwlc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  pwlc_in_t   in_req_i,
  input  pwlc_cmd_t  cmd_i,
  output pwlc_sts_t  sts_o,
  output pwlc_out_t  out_rsp_o
);

  typedef struct packed {
    logic [31:0] min_px;
    logic [31:0] min_val;
    logic [31:0] max_val;
    logic [31:0] slope;
    logic        degen;
  } pwlc_entry_t;

  pwlc_entry_t mem [SEGMENTS];
  pwlc_entry_t rdata_q;
  pwlc_entry_t wr_entry;

  logic [4:0]           count_q;
  logic [SEG_W-1:0]     k_q, k_d, last_q, last_w;
  logic [31:0]          s_q, minpx_q, minv_q, maxv_q, dvs_q, rem_q;
  logic [3:0]           idx_q;
  logic                 num_neg_q, den_neg_q, degen_q, ident_q;
  logic [DQ_W-1:0]      dq_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [32:0]          diff_q;
  logic [49:0]          plo_q;
  logic [47:0]          phi_q;
  logic [64:0]          prod_q;
  logic [48:0]          scaled_q;
  logic [49:0]          sum_q;
  pwlc_out_t            out_q;

  // Request-side values.
  logic [32:0] num_w, den_w;
  logic [31:0] num_mag, den_mag;
  logic        req_ident;

  assign num_w   = {in_req_i.seg_max_pixel[31], in_req_i.seg_max_pixel}
                 - {in_req_i.seg_min_pixel[31], in_req_i.seg_min_pixel};
  assign den_w   = {in_req_i.seg_max_value[31], in_req_i.seg_max_value}
                 - {in_req_i.seg_min_value[31], in_req_i.seg_min_value};
  assign num_mag = num_w[32] ? 32'(33'd0 - num_w) : num_w[31:0];
  assign den_mag = den_w[32] ? 32'(33'd0 - den_w) : den_w[31:0];
  assign req_ident = in_req_i.sample_missing || (count_q == 5'd0);
  assign last_w  = (32'(count_q) > SEGMENTS) ? SEG_W'(SEGMENTS - 1)
                                              : SEG_W'(count_q - 5'd1);

  // Restoring divider step.
  logic [32:0]     div_sh;
  logic            div_ge;
  logic [31:0]     rem_nx;
  logic [DQ_W-1:0] q_neg;
  logic [31:0]     slope_w;

  assign div_sh = {rem_q, dq_q[DQ_W-1]};
  assign div_ge = div_sh >= {1'b0, dvs_q};
  assign rem_nx = div_ge ? 32'(div_sh - {1'b0, dvs_q}) : div_sh[31:0];
  assign q_neg  = '0 - dq_q;

  always_comb begin
    if (degen_q) begin
      slope_w = '0;
    end else if (num_neg_q ^ den_neg_q) begin
      slope_w = (dq_q > DQ_W'(32'h8000_0000)) ? 32'h8000_0000 : q_neg[31:0];
    end else begin
      slope_w = (dq_q > DQ_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : dq_q[31:0];
    end
  end

  assign wr_entry = '{min_px: minpx_q, min_val: minv_q, max_val: maxv_q,
                      slope: slope_w, degen: degen_q};

  // Convert arithmetic.
  logic signed [49:0] plo_w;
  logic signed [47:0] phi_w;
  logic [64:0]        prod_w;
  logic [48:0]        scaled_w;
  logic [49:0]        sum_w;
  logic [33:0]        ipix_w;

  assign plo_w    = $signed({1'b0, diff_q[16:0]}) * $signed(rdata_q.slope);
  assign phi_w    = $signed(diff_q[32:17]) * $signed(rdata_q.slope);
  assign prod_w   = {phi_q, 17'd0} + {{15{plo_q[49]}}, plo_q};
  assign scaled_w = prod_q[64:16] + 49'(prod_q[64] && (|prod_q[15:0]));
  assign sum_w    = {scaled_q[48], scaled_q}
                  + {{18{rdata_q.min_px[31]}}, rdata_q.min_px};
  assign ipix_w   = sum_q[49:16] + 34'(sum_q[49] && (|sum_q[15:0]));

  always_comb begin
    k_d = k_q;
    if (cmd_i.capture) begin
      k_d = '0;
    end else if (cmd_i.srch_adv) begin
      k_d = k_q + 1'b1;
    end
  end

  always_comb begin
    sts_o.req_conv  = (in_req_i.opcode == OP_CONV);
    sts_o.req_ident = req_ident;
    sts_o.req_degen = (den_w == 33'd0);
    sts_o.div_last  = (div_cnt_q == '0);
    sts_o.srch_stop = ($signed(s_q) <= $signed(rdata_q.max_val)) || (k_q == last_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Table: one write port, one registered read port that follows the search index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && (32'(idx_q) < SEGMENTS)) begin
      mem[SEG_W'(idx_q)] <= wr_entry;
    end
    rdata_q <= mem[k_d];
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    if (cmd_i.capture) begin
      idx_q     <= in_req_i.segment_index;
      minpx_q   <= in_req_i.seg_min_pixel;
      minv_q    <= in_req_i.seg_min_value;
      maxv_q    <= in_req_i.seg_max_value;
      num_neg_q <= num_w[32];
      den_neg_q <= den_w[32];
      degen_q   <= (den_w == 33'd0);
      dvs_q     <= den_mag;
      dq_q      <= {num_mag, 16'd0};
      rem_q     <= '0;
      div_cnt_q <= DIV_CNT_W'(DQ_W - 1);
      s_q       <= in_req_i.sample_value;
      ident_q   <= req_ident;
      last_q    <= last_w;
      sum_q     <= in_req_i.sample_missing ? '0
                 : {{18{in_req_i.sample_value[31]}}, in_req_i.sample_value};
    end else begin
      if (cmd_i.div_step) begin
        rem_q     <= rem_nx;
        dq_q      <= {dq_q[DQ_W-2:0], div_ge};
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      if (cmd_i.diff_en) begin
        diff_q <= {s_q[31], s_q} - {rdata_q.min_val[31], rdata_q.min_val};
      end
      if (cmd_i.mlo_en) begin
        plo_q <= plo_w;
      end
      if (cmd_i.mhi_en) begin
        phi_q <= phi_w;
      end
      if (cmd_i.acc_en) begin
        prod_q <= prod_w;
      end
      if (cmd_i.scl_en) begin
        scaled_q <= scaled_w;
      end
      if (cmd_i.sum_en) begin
        sum_q <= sum_w;
      end
    end
    if (cmd_i.out_load) begin
      out_q.pixel              <= ipix_w[7:0];
      out_q.out_of_range       <= ipix_w[33] || (|ipix_w[32:8]);
      out_q.degenerate_segment <= ident_q ? 1'b0 : rdata_q.degen;
      out_q.segment_used       <= ident_q ? 4'd0 : 4'(k_q);
    end
  end

  assign out_rsp_o = out_q;

endmodule

/* hw/rtl/piecewise_linear_calibrator_unit.sv */
// Piecewise linear calibrator: maps signed Q16.16 samples to 8-bit pixel codes through a
// table of up to 16 segments. A load request (opcode 0) stores one segment and its slope,
// (max_pixel - min_pixel) * 65536 / (max_value - min_value), truncated toward zero and
// saturated to 32 bits; equal value bounds store slope 0 and mark the segment degenerate.
// Loads give no result and pass through capture, the bit-serial restoring divider (one
// quotient bit per cycle) and one table write; a load with equal value bounds skips the
// divider. A convert request (opcode 1) gives exactly one result. It scans the table one
// segment per cycle from entry 0 and stops at the first segment whose maximum value is
// not below the sample, or at the last segment in use; then subtract, two half
// multiplies, accumulate, scale, add and round follow one stage each. Missing samples and
// a segment_count of zero skip the table and go straight to the rounding stage. One
// request is processed at a time; the output register lets the next request be accepted
// while a result still waits. The user must write segment_count through
// cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce this.
// Values above 16 act as 16. Reading a segment never loaded since reset gives undefined
// result fields.
module piecewise_linear_calibrator_unit import pwlc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pwlc_in_t   in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pwlc_out_t  out_rsp_o
);

  pwlc_cmd_t cmd;
  pwlc_sts_t sts;

  // Sequence the request: divide for loads, scan and multiply for converts.
  pwlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the segment table, the divider, the multiplier stages and the result register.
  pwlc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

/* test/tb_piecewise_linear_calibrator_unit.sv */
module tb_piecewise_linear_calibrator_unit;
  import pwlc_pkg::*;

  // Loads give no response; settle this long before a
  // segment_count write so a trailing load has surely finished.
  localparam int unsigned IDLE_SETTLE = 64;
  localparam int unsigned MAX_CYCLES  = 1_000_000;
  localparam int unsigned RAND_PER_PHASE = 80;
  localparam int unsigned PHASES = 10;

  // Receiver stall patterns.
  localparam int unsigned STALL_NONE = 0;
  localparam int unsigned STALL_COIN = 1;
  localparam int unsigned STALL_HEAVY = 2;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  pwlc_in_t   in_req_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  pwlc_out_t  out_rsp_o;

  piecewise_linear_calibrator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Requests waiting to be driven, and pixel responses still owed by the block.
  pwlc_in_t  pending_reqs[$];
  pwlc_out_t expected_pixels[$];

  int unsigned cycle_count = 0;
  int unsigned err_count = 0;

  // Calibration table as the block should hold it, updated on every accepted load.
  int         cal_min_px[SEGMENTS];
  int         cal_min_val[SEGMENTS];
  int         cal_max_val[SEGMENTS];
  int         cal_slope[SEGMENTS];
  bit         cal_degen[SEGMENTS];
  logic [4:0] cal_count = '0;

  // Generator-side view of the table: which entries were loaded and their value
  // span, used to aim samples at segment bounds.
  bit gen_loaded[SEGMENTS];
  int gen_lo[SEGMENTS];
  int gen_hi[SEGMENTS];

  // Driver and receiver pacing.
  bit          req_taken = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  bit          drain_hold = 1'b0;
  int unsigned stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  task automatic flag_mismatch(input string what);
    $display("[%0d] mismatch: %s", cycle_count, what);
    err_count++;
  endtask

  // Compute the response of one accepted request; loads update the table and
  // return 0, converts return 1 with the expected pixel fields.
  function automatic bit predict_pixel(input pwlc_in_t r, output pwlc_out_t rsp);
    int          mnp, mxp, mnv, mxv, smp;
    longint      num, den, q, s, diff, prod, scaled, sum, ipix;
    int unsigned n, k;
    rsp = '0;
    if (r.opcode == OP_LOAD) begin
      mnp = r.seg_min_pixel;
      mxp = r.seg_max_pixel;
      mnv = r.seg_min_value;
      mxv = r.seg_max_value;
      num = longint'(mxp) - longint'(mnp);
      den = longint'(mxv) - longint'(mnv);
      q = 0;
      if (den != 0) begin
        q = (num * 65536) / den;
        // saturate the slope to 32 bits
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      cal_min_px[r.segment_index]  = mnp;
      cal_min_val[r.segment_index] = mnv;
      cal_max_val[r.segment_index] = mxv;
      cal_slope[r.segment_index]   = int'(q);
      cal_degen[r.segment_index]   = (den == 0);
      return 1'b0;
    end
    smp = r.sample_value;
    s = longint'(smp);
    n = (cal_count > SEGMENTS) ? SEGMENTS : cal_count;
    ipix = 0;
    if (!r.sample_missing) begin
      if (n == 0) begin
        ipix = s / 65536;
      end else begin
        // first segment whose top is not below the sample, else the last in use
        k = 0;
        while (k < n && s > longint'(cal_max_val[k])) k++;
        if (k >= n) k = n - 1;
        diff   = s - longint'(cal_min_val[k]);
        prod   = diff * longint'(cal_slope[k]);
        scaled = prod / 65536;
        sum    = scaled + longint'(cal_min_px[k]);
        ipix   = sum / 65536;
        rsp.segment_used       = k[3:0];
        rsp.degenerate_segment = cal_degen[k];
      end
    end
    rsp.pixel        = ipix[7:0];
    rsp.out_of_range = (ipix < 0 || ipix > 255);
    return 1'b1;
  endfunction

  // Q16.16 word drawn from a mix of full range, small spans around zero, values from 0 up to 256 and corner values.
  function automatic int rand_q16();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return int'($urandom_range(0, 600 << 16)) - (300 << 16);
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return int'($urandom_range(0, 255) << 16) | int'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic push_load(input int idx, input int minpx, input int maxpx,
                           input int minv, input int maxv);
    pwlc_in_t item;
    item.opcode         = OP_LOAD;
    item.segment_index  = idx[3:0];
    item.seg_min_pixel  = minpx;
    item.seg_max_pixel  = maxpx;
    item.seg_min_value  = minv;
    item.seg_max_value  = maxv;
    // don't-care fields carry noise
    item.sample_value   = $urandom;
    item.sample_missing = 1'($urandom_range(0, 1));
    pending_reqs.push_back(item);
    gen_loaded[idx] = 1'b1;
    gen_lo[idx] = minv;
    gen_hi[idx] = maxv;
  endtask

  task automatic push_convert(input int sample, input bit missing);
    pwlc_in_t item;
    item.opcode         = OP_CONV;
    item.segment_index  = 4'($urandom_range(0, 15));
    item.seg_min_pixel  = $urandom;
    item.seg_max_pixel  = $urandom;
    item.seg_min_value  = $urandom;
    item.seg_max_value  = $urandom;
    item.sample_value   = sample;
    item.sample_missing = missing;
    pending_reqs.push_back(item);
  endtask

  // Well-formed table: rising value bounds, pixel spans mostly rising, some
  // segments of zero width.
  task automatic build_table(input int unsigned n);
    int v, p, w, pw;
    v = int'($urandom_range(0, 200 << 16)) - (100 << 16);
    p = int'($urandom_range(0, 40) << 16);
    for (int unsigned k = 0; k < n; k++) begin
      w  = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 40 << 16));
      pw = int'($urandom_range(0, 60 << 16));
      if ($urandom_range(0, 3) == 0) pw = -pw;
      push_load(k, p, p + pw, v, v + w);
      v += w;
      p += pw;
    end
  endtask

  task automatic random_load();
    int idx, v, w;
    idx = $urandom_range(0, 15);
    case ($urandom_range(0, 3))
      0: push_load(idx, rand_q16(), rand_q16(), rand_q16(), rand_q16());
      1: begin
        v = rand_q16();
        push_load(idx, rand_q16(), rand_q16(), v, v);
      end
      default: begin
        v = int'($urandom_range(0, 400 << 16)) - (200 << 16);
        w = int'($urandom_range(1, 40 << 16));
        push_load(idx, int'($urandom_range(0, 255 << 16)), int'($urandom_range(0, 255 << 16)),
                  v, v + w);
      end
    endcase
  endtask

  // Aim most samples at or near a segment bound or at a segment midpoint (tests the
  // not-below compare), the rest anywhere.
  task automatic random_convert(input int unsigned n);
    int k, off, smp;
    bit miss;
    miss = ($urandom_range(0, 9) == 0);
    if (n != 0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, n - 1);
      off = int'($urandom_range(0, 4)) - 2;
      case ($urandom_range(0, 2))
        0: smp = gen_hi[k] + off;
        1: smp = gen_lo[k] + off;
        default: smp = gen_lo[k] / 2 + gen_hi[k] / 2;
      endcase
    end else begin
      smp = rand_q16();
    end
    push_convert(smp, miss);
  endtask

  // Wait until every request went in and every response came out, then let
  // any trailing load finish.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_segment_count(input logic [4:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    cal_count    = value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Stimulus: directed corners, then phases under different segment counts.
  initial begin
    int unsigned counts[PHASES] = '{16, 31, 1, 0, 5, 17, 8, 2, 16, 12};
    int unsigned n_eff;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // identity mapping while segment_count is still zero: extremes, rounding toward zero, top pixel versus out of range
    push_convert(32'h7FFF_FFFF, 1'b0);
    push_convert(32'h8000_0000, 1'b0);
    push_convert(-1, 1'b0);
    push_convert((255 << 16) | 16'hFFFF, 1'b0);
    push_convert(256 << 16, 1'b0);
    push_convert(32'h7FFF_FFFF, 1'b1);
    wait_idle();

    write_segment_count(5'd4);
    // equal value bounds: slope 0, degenerate flag
    push_load(0, 7 << 16, 9 << 16, -(100 << 16), -(100 << 16));
    // slope saturates high
    push_load(1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
    // widest reversed value span
    push_load(2, 0, 255 << 16, 32'h7FFF_FFFF, 32'h8000_0000);
    // slope saturates low
    push_load(3, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
    push_convert(32'h8000_0000, 1'b0);
    push_convert(1, 1'b0);
    push_convert(0, 1'b0);
    // both of these pass every bound and fall back to the last segment
    push_convert(2, 1'b0);
    push_convert(32'h7FFF_FFFF, 1'b0);
    push_convert(0, 1'b1);
    wait_idle();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      write_segment_count(counts[ph][4:0]);
      n_eff = (counts[ph] > SEGMENTS) ? SEGMENTS : counts[ph];
      // never let a convert read an entry that was not loaded
      for (int unsigned k = 0; k < n_eff; k++)
        if (!gen_loaded[k]) push_load(k, int'($urandom_range(0, 255 << 16)),
                                      int'($urandom_range(0, 255 << 16)),
                                      int'(k) << 20, (int'(k) << 20) + (1 << 19));
      if ($urandom_range(0, 1) == 1) build_table(n_eff);
      repeat (RAND_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0) random_load();
        else random_convert(n_eff);
      end
      wait_idle();
    end

    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Note acceptance and predict at the same edge the block takes the request.
  always @(posedge clk_i) begin
    pwlc_out_t rsp;
    if (rst_ni && in_valid_i && in_ready_o) begin
      req_taken = 1'b1;
      if (predict_pixel(in_req_i, rsp)) expected_pixels.push_back(rsp);
    end
  end

  // Request driver: hold until accepted, then issue in bursts with gaps; now and
  // then stop after a burst until all responses have drained.
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = in_valid_i && !req_taken;
    req_taken = 1'b0;
    if (drain_hold && expected_pixels.size() == 0) drain_hold = 1'b0;
    if (rst_ni && !nxt_valid && !drain_hold) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        in_req_i <= pending_reqs.pop_front();
        nxt_valid = 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
          if ($urandom_range(0, 24) == 0) drain_hold = 1'b1;
        end
      end
    end
    in_valid_i <= nxt_valid;
  end

  // Receiver: switch between randomly chosen stall patterns.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE: out_ready_i <= 1'b1;
      STALL_COIN: out_ready_i <= 1'($urandom_range(0, 1));
      default:    out_ready_i <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Response monitor: compare each accepted response with the oldest prediction.
  always @(posedge clk_i) begin
    pwlc_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        flag_mismatch("response with no request outstanding");
      end else begin
        want = expected_pixels.pop_front();
        if (out_rsp_o.pixel !== want.pixel)
          flag_mismatch($sformatf("pixel got %0d want %0d", out_rsp_o.pixel, want.pixel));
        if (out_rsp_o.out_of_range !== want.out_of_range)
          flag_mismatch($sformatf("out_of_range got %b want %b",
                                  out_rsp_o.out_of_range, want.out_of_range));
        if (out_rsp_o.degenerate_segment !== want.degenerate_segment)
          flag_mismatch($sformatf("degenerate_segment got %b want %b",
                                  out_rsp_o.degenerate_segment, want.degenerate_segment));
        if (out_rsp_o.segment_used !== want.segment_used)
          flag_mismatch($sformatf("segment_used got %0d want %0d",
                                  out_rsp_o.segment_used, want.segment_used));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

/* piecewise_linear_calibrator_unit.f */
hw/rtl/pwlc_pkg.sv
hw/rtl/pwlc_ctrl.sv
hw/rtl/pwlc_dp.sv
hw/rtl/piecewise_linear_calibrator_unit.sv
test/tb_piecewise_linear_calibrator_unit.sv
